// File: rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants for the rational arithmetic unit: operation
// codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package rau_pkg;

	// width of each operand field on the stream
	localparam int unsigned FIELD_W = 32;

	// low two mode bits pick the arithmetic operation
	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	// which product the shared multiplier forms
	typedef enum logic [1:0] {
		MUL_A = 2'd0,
		MUL_B = 2'd1,
		MUL_C = 2'd2
	} mul_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_A,
		S_MUL_B,
		S_MUL_C,
		S_FORM,
		S_CHECK,
		S_GCD,
		S_GSHIFT,
		S_DIV_NUM,
		S_DIV_DEN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic     capture;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     form;
		logic     gcd_step;
		logic     gshift;
		logic     div_load;
		logic     div_sel_den;
		logic     div_step;
		logic     save_num;
		logic     save_den;
		logic     load_out;
	} cmd_t;

	typedef struct packed {
		logic op_zero;
		logic is_cmp;
		logic is_addsub;
		logic den_zero;
		logic gcd_done;
		logic div_done;
	} sts_t;

endpackage

// File: rtl/rational_arith_unit.sv
// ----------------------------------------------------------------------------
// rational_arith_unit
// Exact add, subtract, multiply, divide and equality compare of two signed
// fractions, with the result reduced by its greatest common divisor.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis carries one operation per transfer: tuser holds the mode, tdata the
//  four operands. m_axis returns exactly one result per accepted transfer.
//  One item is worked on at a time; s_axis_tready is high only while idle.
//  A zero operand denominator or a zero result denominator ends the item
//  early with an error result, and compare finishes after the two cross
//  products; arithmetic runs the multiply, form and check steps, the binary
//  gcd (one subtract a cycle) and two divisions through the one restoring
//  divider.
//  The finished result sits in an output register; the block may take the
//  next item while it waits, and holds its own result back until the
//  register is free. A stalled receiver therefore holds one result in the
//  register and one finished item inside, and the input stays blocked.
//  Reset empties the output register and returns the controller to idle.
// ----------------------------------------------------------------------------
module rational_arith_unit #(
	parameter int unsigned OPERAND_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // a_num, a_den, b_num, b_den
	input  logic [2:0]   s_axis_tuser,  // mode
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,  // res_num, res_den, equal
	output logic [0:0]   m_axis_tuser   // status
);

	rau_pkg::cmd_t cmd;
	rau_pkg::sts_t sts;
	logic [63:0]   res_num;
	logic [62:0]   res_den;
	logic          equal;
	logic          status;

	rau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	rau_dp #(
		.W (OPERAND_WIDTH)
	) u_dp (
		.clk     (clk),
		.cmd     (cmd),
		.sts     (sts),
		.in_mode (s_axis_tuser),
		.in_data (s_axis_tdata),
		.res_num (res_num),
		.res_den (res_den),
		.equal   (equal),
		.status  (status)
	);

	// pack the result transfer
	assign m_axis_tdata = {equal, res_den, res_num};
	assign m_axis_tuser = status;

`ifndef SYNTHESIS
	// one item in flight: no second transfer straight after the first
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input taken while busy");

	// an error result carries all-zero data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
		else $error("error result with nonzero data");

	// equal only reported with no fraction in the result
	a_eq_den: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[126:64] != '0) |-> !m_axis_tdata[127])
		else $error("equal set on an arithmetic result");
`endif

endmodule

// File: rtl/rau_dp.sv
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: operand registers, shared signed multiplier, sign/magnitude
// forming, binary GCD and a restoring divider, result registers.
// ----------------------------------------------------------------------------
module rau_dp #(
	parameter int unsigned W = 32
) (
	input  logic                          clk,
	input  rau_pkg::cmd_t                 cmd,
	output rau_pkg::sts_t                 sts,
	input  logic [2:0]                    in_mode,
	input  logic [4*rau_pkg::FIELD_W-1:0] in_data,
	output logic [63:0]                   res_num,
	output logic [62:0]                   res_den,
	output logic                          equal,
	output logic                          status
);

	localparam int unsigned MW = 2 * W;
	localparam int unsigned KW = $clog2(MW);
	localparam int unsigned CW = $clog2(MW + 1);
	localparam int unsigned FW = rau_pkg::FIELD_W;

	logic [2:0]             mode_q;
	logic signed [W-1:0]    an_q, ad_q, bn_q, bd_q;
	logic signed [W-1:0]    ma, mb;
	logic signed [MW-1:0]   prod;
	logic signed [MW-1:0]   pa_q, pb_q, pc_q;
	logic signed [MW:0]     pa_e, pb_e, pc_e, num_w, den_w, num_n, den_n;
	logic [MW-1:0]          num_mag, den_mag;
	logic                   num_neg, den_neg;
	logic [MW-1:0]          n0_q, d0_q, u_q, v_q, g_q, quo_q, rem_q, rn_q, rd_q;
	logic [KW-1:0]          k_q;
	logic [CW-1:0]          cnt_q;
	logic                   neg_q;
	logic [MW:0]            rem_sh, g_e, rem_d;
	logic                   ge;
	logic                   is_cmp, err;
	logic                   op_mul;
	logic [63:0]            mag64, packed_num;
	rau_pkg::op_t           op;
	logic [63:0]            res_num_q;
	logic [62:0]            res_den_q;
	logic                   equal_q, status_q;

	assign op     = rau_pkg::op_t'(mode_q[1:0]);
	assign is_cmp = mode_q[2];
	// compare always cross-multiplies, whatever the low mode bits say
	assign op_mul = (op == rau_pkg::OP_MUL) && !is_cmp;

	// status back to the controller
	assign sts.op_zero   = (ad_q == '0) || (bd_q == '0);
	assign sts.is_cmp    = is_cmp;
	assign sts.is_addsub = (op == rau_pkg::OP_ADD) || (op == rau_pkg::OP_SUB);
	assign sts.den_zero  = (d0_q == '0);
	assign sts.gcd_done  = (u_q == '0);
	assign sts.div_done  = (cnt_q == '0);

	// operand capture, low W bits of each field read as two's complement
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= in_mode;
			an_q   <= in_data[0*FW +: W];
			ad_q   <= in_data[1*FW +: W];
			bn_q   <= in_data[2*FW +: W];
			bd_q   <= in_data[3*FW +: W];
		end
	end

	// multiplier operand selection
	always_comb begin
		unique case (cmd.mul_sel)
			rau_pkg::MUL_A: begin
				ma = an_q;
				mb = op_mul ? bn_q : bd_q;
			end
			rau_pkg::MUL_B: begin
				ma = op_mul ? ad_q : bn_q;
				mb = op_mul ? bd_q : ad_q;
			end
			default: begin
				ma = ad_q;
				mb = bd_q;
			end
		endcase
	end

	assign prod = MW'(ma) * MW'(mb);

	// products land in their own registers
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			unique case (cmd.mul_sel)
				rau_pkg::MUL_A: pa_q <= prod;
				rau_pkg::MUL_B: pb_q <= prod;
				default:        pc_q <= prod;
			endcase
		end
	end

	// unreduced numerator and denominator as sign and magnitude
	assign pa_e = {pa_q[MW-1], pa_q};
	assign pb_e = {pb_q[MW-1], pb_q};
	assign pc_e = {pc_q[MW-1], pc_q};

	always_comb begin
		unique case (op)
			rau_pkg::OP_ADD: begin
				num_w = pa_e + pb_e;
				den_w = pc_e;
			end
			rau_pkg::OP_SUB: begin
				num_w = pa_e - pb_e;
				den_w = pc_e;
			end
			default: begin
				num_w = pa_e;
				den_w = pb_e;
			end
		endcase
	end

	assign num_neg = num_w[MW];
	assign den_neg = den_w[MW];
	assign num_n   = -num_w;
	assign den_n   = -den_w;
	assign num_mag = num_neg ? num_n[MW-1:0] : num_w[MW-1:0];
	assign den_mag = den_neg ? den_n[MW-1:0] : den_w[MW-1:0];

	// binary gcd, one step a cycle
	always_ff @(posedge clk) begin
		if (cmd.form) begin
			n0_q  <= num_mag;
			d0_q  <= den_mag;
			u_q   <= num_mag;
			v_q   <= den_mag;
			k_q   <= '0;
			neg_q <= (num_neg ^ den_neg) & (num_mag != '0);
		end else if (cmd.gcd_step) begin
			priority if (!u_q[0] && !v_q[0]) begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
				k_q <= k_q + KW'(1);
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (u_q >= v_q) begin
				u_q <= (u_q - v_q) >> 1;
			end else begin
				v_q <= (v_q - u_q) >> 1;
			end
		end
	end

	// restoring divider shared by numerator and denominator
	assign rem_sh = {rem_q, quo_q[MW-1]};
	assign g_e    = {1'b0, g_q};
	assign ge     = (rem_sh >= g_e);
	assign rem_d  = ge ? (rem_sh - g_e) : rem_sh;

	always_ff @(posedge clk) begin
		if (cmd.gshift) begin
			g_q <= v_q << k_q;
		end
		if (cmd.div_load) begin
			quo_q <= cmd.div_sel_den ? d0_q : n0_q;
			rem_q <= '0;
			cnt_q <= CW'(MW);
		end else if (cmd.div_step) begin
			rem_q <= rem_d[MW-1:0];
			quo_q <= {quo_q[MW-2:0], ge};
			cnt_q <= cnt_q - CW'(1);
		end
		if (cmd.save_num) begin
			rn_q <= quo_q;
		end
		if (cmd.save_den) begin
			rd_q <= quo_q;
		end
	end

	// pack numerator as signed 64-bit, saturating a positive overflow
	assign mag64 = 64'(rn_q);
	always_comb begin
		priority if (!neg_q && mag64[63]) begin
			packed_num = {1'b0, {63{1'b1}}};
		end else if (neg_q) begin
			packed_num = -mag64;
		end else begin
			packed_num = mag64;
		end
	end

	assign err = sts.op_zero | (!is_cmp & sts.den_zero);

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_num_q <= (err || is_cmp) ? '0 : packed_num;
			res_den_q <= (err || is_cmp) ? '0 : 63'(rd_q);
			equal_q   <= !err && is_cmp && (pa_q == pb_q);
			status_q  <= err;
		end
	end

	assign res_num = res_num_q;
	assign res_den = res_den_q;
	assign equal   = equal_q;
	assign status  = status_q;

endmodule

// File: rtl/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl
// Controller: sequences multiply, form, gcd and divide steps and owns the
// stream handshakes.
// ----------------------------------------------------------------------------
module rau_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output rau_pkg::cmd_t cmd,
	input  rau_pkg::sts_t sts
);

	rau_pkg::state_t state_q, state_d;
	logic            ovalid_q;

	// state register and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rau_pkg::S_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign out_valid = ovalid_q;
	assign in_ready  = (state_q == rau_pkg::S_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rau_pkg::S_IDLE:    if (in_valid) state_d = rau_pkg::S_MUL_A;
			rau_pkg::S_MUL_A:   state_d = sts.op_zero ? rau_pkg::S_FINISH : rau_pkg::S_MUL_B;
			rau_pkg::S_MUL_B: begin
				priority if (sts.is_cmp) state_d = rau_pkg::S_FINISH;
				else if (sts.is_addsub) state_d = rau_pkg::S_MUL_C;
				else state_d = rau_pkg::S_FORM;
			end
			rau_pkg::S_MUL_C:   state_d = rau_pkg::S_FORM;
			rau_pkg::S_FORM:    state_d = rau_pkg::S_CHECK;
			rau_pkg::S_CHECK:   state_d = sts.den_zero ? rau_pkg::S_FINISH : rau_pkg::S_GCD;
			rau_pkg::S_GCD:     if (sts.gcd_done) state_d = rau_pkg::S_GSHIFT;
			rau_pkg::S_GSHIFT:  state_d = rau_pkg::S_DIV_NUM;
			rau_pkg::S_DIV_NUM: if (sts.div_done) state_d = rau_pkg::S_DIV_DEN;
			rau_pkg::S_DIV_DEN: if (sts.div_done) state_d = rau_pkg::S_FINISH;
			rau_pkg::S_FINISH:  if (!ovalid_q || out_ready) state_d = rau_pkg::S_IDLE;
			default:            state_d = rau_pkg::S_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd = '0;
		cmd.mul_sel = rau_pkg::MUL_A;
		unique case (state_q)
			rau_pkg::S_IDLE:  cmd.capture = in_valid;
			rau_pkg::S_MUL_A: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = rau_pkg::MUL_A;
			end
			rau_pkg::S_MUL_B: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = rau_pkg::MUL_B;
			end
			rau_pkg::S_MUL_C: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = rau_pkg::MUL_C;
			end
			rau_pkg::S_FORM:  cmd.form = 1'b1;
			rau_pkg::S_CHECK: ;
			rau_pkg::S_GCD:   cmd.gcd_step = !sts.gcd_done;
			rau_pkg::S_GSHIFT: begin
				cmd.gshift   = 1'b1;
				cmd.div_load = 1'b1;
			end
			rau_pkg::S_DIV_NUM: begin
				cmd.div_step    = !sts.div_done;
				cmd.save_num    = sts.div_done;
				cmd.div_load    = sts.div_done;
				cmd.div_sel_den = 1'b1;
			end
			rau_pkg::S_DIV_DEN: begin
				cmd.div_step = !sts.div_done;
				cmd.save_den = sts.div_done;
			end
			rau_pkg::S_FINISH: cmd.load_out = !ovalid_q || out_ready;
			default: ;
		endcase
	end

endmodule
